// ===== hdl/iq_packet_deframer_dc_remove_assert.svh =====
// Assertion macros for the I/Q deframer with DC removal.
`ifndef IQ_PACKET_DEFRAMER_DC_REMOVE_ASSERT_SVH
`define IQ_PACKET_DEFRAMER_DC_REMOVE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// clocked on clk, quiet while arst_n is low
`define IQDFDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked on clk, checked during reset too
`define IQDFDC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IQDFDC_ASSERT(lbl, prop, msg)
`define IQDFDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/iqdfdc_pkg.sv =====
// Types and constants for the I/Q deframer with DC removal.
`timescale 1ns / 1ps
package iqdfdc_pkg;

	localparam logic [10:0] PACKET_BYTES       = 11'd1028;
	localparam logic [21:0] SAMPLE_RATE_RESET  = 22'd48000;

	localparam int RATE_W    = 22;
	localparam int COUNT_W   = 23;
	localparam int SUM_W     = 56;
	localparam int AVG_W     = 32;
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic {
		OP_HEADER = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef enum logic {
		REG_SAMPLE_RATE = 1'b0,
		REG_REMOVE_DC   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_DC,
		ST_ACC_Q,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_END,
		ST_OUT
	} state_t;

endpackage

// ===== hdl/iqdfdc_if.sv =====
// Request channels: deframer input items and result items.
`timescale 1ns / 1ps
interface iqdfdc_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [10:0]        payload_length;
	logic [15:0]        sequence_req;
	logic               key_down;
	logic signed [15:0] sample_i;
	logic signed [15:0] sample_q;

	modport source (
		output valid, opcode, payload_length, sequence_req, key_down, sample_i, sample_q,
		input  ready
	);
	modport sink (
		input  valid, opcode, payload_length, sequence_req, key_down, sample_i, sample_q,
		output ready
	);
endinterface

interface iqdfdc_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic signed [32:0] out_i;
	logic signed [32:0] out_q;
	logic               packet_ok;
	logic               sequence_ok;
	logic [31:0]        read_errors;

	modport source (
		output valid, result_kind, out_i, out_q, packet_ok, sequence_ok, read_errors,
		input  ready
	);
	modport sink (
		input  valid, result_kind, out_i, out_q, packet_ok, sequence_ok, read_errors,
		output ready
	);
endinterface

// ===== hdl/iq_packet_deframer_dc_remove.sv =====
// Top level: receiver packet deframer with sequence check and DC offset removal.
//
// One request at a time. A header goes through the header check to the output;
// a sample accumulates I, then Q (once settled, with the key up), through one shared
// 56-bit adder, and a dropped sample returns to idle. When the averaging window
// closes, both averages come from one restoring divider, one quotient bit a cycle,
// before that sample's result. A finished result sits in the output register, and
// the next request is taken while it waits; the block stalls only if a second
// result is ready first. State clears at reset; there is no clearing pass.
`timescale 1ns / 1ps
`include "iq_packet_deframer_dc_remove_assert.svh"
module iq_packet_deframer_dc_remove (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	iqdfdc_in_if.sink           in_ch,
	iqdfdc_out_if.source        out_ch
);
	import iqdfdc_pkg::*;

	state_t state_q, state_d;

	// config
	logic [RATE_W-1:0] sample_rate_q;
	logic              remove_dc_q;
	logic              cfg_wr;

	// latched request
	logic               opcode_q;
	logic [10:0]        length_q;
	logic [15:0]        seq_q;
	logic               key_in_q;
	logic signed [15:0] smp_i_q;
	logic signed [15:0] smp_q_q;

	// tracking state
	logic [15:0]              exp_seq_q;
	logic                     packet_good_q;
	logic                     seq_ok_q;
	logic                     key_latched_q;
	logic [31:0]              err_cnt_q;
	logic [RATE_W-1:0]        settle_q;
	logic signed [SUM_W-1:0]  sum_i_q;
	logic signed [SUM_W-1:0]  sum_q_q;
	logic [COUNT_W-1:0]       dc_count_q;
	logic signed [AVG_W-1:0]  avg_i_q;
	logic signed [AVG_W-1:0]  avg_q_q;

	// divider
	logic                     div_sel_q;
	logic                     div_neg_q;
	logic [SUM_W-1:0]         div_num_q;
	logic [COUNT_W-1:0]       div_rem_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [COUNT_W:0]         div_rem_sh;
	logic                     div_ge;
	logic [COUNT_W:0]         div_diff;
	logic signed [SUM_W-1:0]  div_src;
	logic [SUM_W-1:0]         div_abs;
	logic [AVG_W-1:0]         div_quo;

	// shared accumulate adder
	logic signed [31:0]       x_i, x_q;
	logic signed [SUM_W-1:0]  acc_a, acc_b, acc_sum;

	// control
	logic in_take, out_free, load_out, settling, window_full;
	logic signed [32:0] res_i, res_q;

	// output register
	logic               out_valid_q;
	logic               kind_q;
	logic signed [32:0] out_i_q, out_q_q;
	logic               pkt_ok_out_q, seq_ok_out_q;
	logic [31:0]        errors_out_q;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SAMPLE_RATE: prdata = {{(32 - RATE_W){1'b0}}, sample_rate_q};
			REG_REMOVE_DC:   prdata = {31'd0, remove_dc_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SAMPLE_RATE_RESET;
			remove_dc_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SAMPLE_RATE: sample_rate_q <= pwdata[RATE_W-1:0];
				REG_REMOVE_DC:   remove_dc_q   <= pwdata[0];
				default:         ;
			endcase
		end
	end

	// datapath helpers
	assign x_i = {smp_i_q, 16'h0000};
	assign x_q = {smp_q_q, 16'h0000};

	assign acc_a   = (state_q == ST_DC) ? sum_i_q : sum_q_q;
	assign acc_b   = (state_q == ST_DC) ? SUM_W'(x_i) : SUM_W'(x_q);
	assign acc_sum = acc_a + acc_b;

	assign settling    = {1'b0, settle_q} < {1'b0, sample_rate_q};
	assign window_full = dc_count_q > {sample_rate_q, 1'b0};

	assign div_src    = div_sel_q ? sum_q_q : sum_i_q;
	assign div_abs    = div_src[SUM_W-1] ? SUM_W'(-div_src) : SUM_W'(div_src);
	assign div_rem_sh = {div_rem_q, div_num_q[SUM_W-1]};
	assign div_ge     = div_rem_sh >= {1'b0, dc_count_q};
	assign div_diff   = div_rem_sh - {1'b0, dc_count_q};
	assign div_quo    = div_neg_q ? (~div_num_q[AVG_W-1:0] + AVG_W'(1)) : div_num_q[AVG_W-1:0];

	assign res_i = 33'(x_i) - (remove_dc_q ? 33'(avg_i_q) : 33'sd0);
	assign res_q = 33'(x_q) - (remove_dc_q ? 33'(avg_q_q) : 33'sd0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid)
					state_d = (opcode_t'(in_ch.opcode) == OP_HEADER) ? ST_HDR : ST_DC;
			end
			ST_HDR: state_d = ST_OUT;
			ST_DC: begin
				if (!packet_good_q)
					state_d = ST_IDLE;
				else if (key_latched_q || settling)
					state_d = ST_OUT;
				else
					state_d = ST_ACC_Q;
			end
			ST_ACC_Q:    state_d = window_full ? ST_DIV_LOAD : ST_OUT;
			ST_DIV_LOAD: state_d = ST_DIV_STEP;
			ST_DIV_STEP: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = ST_DIV_END;
			end
			ST_DIV_END: state_d = div_sel_q ? ST_OUT : ST_DIV_LOAD;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_free    = !out_valid_q || out_ch.ready;
		in_ch.ready = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_OUT:  load_out    = out_free;
			default: ;
		endcase
	end

	assign in_take = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_q <= in_ch.opcode;
			length_q <= in_ch.payload_length;
			seq_q    <= in_ch.sequence_req;
			key_in_q <= in_ch.key_down;
			smp_i_q  <= in_ch.sample_i;
			smp_q_q  <= in_ch.sample_q;
		end
	end

	// header check and DC tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_seq_q     <= '0;
			packet_good_q <= 1'b0;
			seq_ok_q      <= 1'b0;
			key_latched_q <= 1'b0;
			err_cnt_q     <= '0;
			settle_q      <= '0;
			sum_i_q       <= '0;
			sum_q_q       <= '0;
			dc_count_q    <= '0;
			avg_i_q       <= '0;
			avg_q_q       <= '0;
			div_sel_q     <= 1'b0;
			div_cnt_q     <= '0;
		end else begin
			case (state_q)
				ST_HDR: begin
					key_latched_q <= key_in_q;
					seq_ok_q      <= 1'b0;
					if (length_q != PACKET_BYTES) begin
						packet_good_q <= 1'b0;
						err_cnt_q     <= err_cnt_q + 32'd1;
					end else begin
						packet_good_q <= 1'b1;
						exp_seq_q     <= seq_q + 16'd1;
						if (seq_q == exp_seq_q)
							seq_ok_q <= 1'b1;
						else
							err_cnt_q <= err_cnt_q + 32'd1;
					end
				end
				ST_DC: begin
					if (packet_good_q) begin
						if (key_latched_q) begin
							settle_q   <= '0;
							sum_i_q    <= '0;
							sum_q_q    <= '0;
							dc_count_q <= '0;
						end else if (settling) begin
							settle_q <= settle_q + RATE_W'(1);
						end else begin
							dc_count_q <= dc_count_q + COUNT_W'(1);
							sum_i_q    <= acc_sum;
						end
					end
				end
				ST_ACC_Q: sum_q_q <= acc_sum;
				ST_DIV_LOAD: div_cnt_q <= '0;
				ST_DIV_STEP: div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				ST_DIV_END: begin
					if (div_sel_q) begin
						avg_q_q    <= div_quo;
						sum_i_q    <= '0;
						sum_q_q    <= '0;
						dc_count_q <= '0;
						div_sel_q  <= 1'b0;
					end else begin
						avg_i_q   <= div_quo;
						div_sel_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIV_LOAD: begin
				div_num_q <= div_abs;
				div_neg_q <= div_src[SUM_W-1];
				div_rem_q <= '0;
			end
			ST_DIV_STEP: begin
				div_num_q <= {div_num_q[SUM_W-2:0], div_ge};
				div_rem_q <= div_ge ? div_diff[COUNT_W-1:0] : div_rem_sh[COUNT_W-1:0];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			errors_out_q <= err_cnt_q;
			if (opcode_t'(opcode_q) == OP_HEADER) begin
				kind_q       <= KIND_STATUS;
				out_i_q      <= '0;
				out_q_q      <= '0;
				pkt_ok_out_q <= packet_good_q;
				seq_ok_out_q <= seq_ok_q;
			end else begin
				kind_q       <= KIND_SAMPLE;
				out_i_q      <= res_i;
				out_q_q      <= res_q;
				pkt_ok_out_q <= 1'b0;
				seq_ok_out_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = kind_q;
	assign out_ch.out_i       = out_i_q;
	assign out_ch.out_q       = out_q_q;
	assign out_ch.packet_ok   = pkt_ok_out_q;
	assign out_ch.sequence_ok = seq_ok_out_q;
	assign out_ch.read_errors = errors_out_q;

	`IQDFDC_ASSERT(a_busy_after_take, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "request taken while busy")
	`IQDFDC_ASSERT(a_div_bound, (state_q == ST_DIV_STEP) |-> (div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1)), "divider overran")
	`IQDFDC_ASSERT(a_window_clear, (state_q == ST_DIV_END && div_sel_q) |=> (dc_count_q == '0 && !div_sel_q), "window not cleared")
	`IQDFDC_ASSERT(a_out_hold, (state_q == ST_OUT && out_valid_q && !out_ch.ready) |=> (state_q == ST_OUT && out_valid_q), "result overwritten")
	`IQDFDC_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")

endmodule

// ===== dv/tb.sv =====
// Testbench for the I/Q packet deframer with DC removal: predicted results checked against the block.
`timescale 1ns / 1ps
module tb;
	import iqdfdc_pkg::*;

	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		opcode_t            opcode;
		logic [10:0]        payload_length;
		logic [15:0]        sequence_req;
		logic               key_down;
		logic signed [15:0] sample_i;
		logic signed [15:0] sample_q;
	} deframe_req_t;

	typedef struct packed {
		kind_t              result_kind;
		logic signed [32:0] out_i;
		logic signed [32:0] out_q;
		logic               packet_ok;
		logic               sequence_ok;
		logic [31:0]        read_errors;
	} deframe_result_t;

	class deframer_board;
		logic [21:0] rate = SAMPLE_RATE_RESET;
		logic        remove_dc = 1'b0;
		logic [15:0] next_seq = '0;
		logic        pkt_good = 1'b0;
		logic [31:0] err_count = '0;
		logic        key_held = 1'b0;
		longint      settle = 0;
		longint      win = 0;
		longint      sum_i = 0;
		longint      sum_q = 0;
		longint      avg_i = 0;
		longint      avg_q = 0;
		int          predicted = 0;
		int          mismatches = 0;
		deframe_result_t due_outputs[$];

		function void set_register(reg_idx_t idx, logic [31:0] v);
			if (idx == REG_SAMPLE_RATE)
				rate = v[21:0];
			else
				remove_dc = v[0];
		endfunction

		function void track_dc(longint xi, longint xq);
			if (key_held) begin
				settle = 0;
				win = 0;
				sum_i = 0;
				sum_q = 0;
			end else if (settle < longint'(rate)) begin
				settle++;
			end else begin
				win++;
				sum_i += xi;
				sum_q += xq;
				if (win > 2 * longint'(rate)) begin
					avg_i = sum_i / win;
					avg_q = sum_q / win;
					sum_i = 0;
					sum_q = 0;
					win = 0;
				end
			end
		endfunction

		function void note_request(deframe_req_t r);
			deframe_result_t e;
			longint xi, xq;
			e = '0;
			if (r.opcode == OP_HEADER) begin
				key_held = r.key_down;
				if (r.payload_length != PACKET_BYTES) begin
					pkt_good = 1'b0;
					err_count++;
				end else begin
					pkt_good = 1'b1;
					if (r.sequence_req == next_seq)
						e.sequence_ok = 1'b1;
					else
						err_count++;
					next_seq = r.sequence_req + 16'd1;
				end
				e.result_kind = KIND_STATUS;
				e.packet_ok = pkt_good;
			end else begin
				if (!pkt_good)
					return;
				xi = longint'(r.sample_i) * 65536;
				xq = longint'(r.sample_q) * 65536;
				track_dc(xi, xq);
				if (remove_dc) begin
					xi -= avg_i;
					xq -= avg_q;
				end
				e.result_kind = KIND_SAMPLE;
				e.out_i = xi[32:0];
				e.out_q = xq[32:0];
			end
			e.read_errors = err_count;
			due_outputs.push_back(e);
			predicted++;
		endfunction

		function void check_result(deframe_result_t got);
			deframe_result_t e;
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d i %0d q %0d ok %0b seq %0b err %0d",
						got.result_kind, got.out_i, got.out_q, got.packet_ok,
						got.sequence_ok, got.read_errors);
				return;
			end
			e = due_outputs.pop_front();
			if (got.result_kind !== e.result_kind || got.out_i !== e.out_i ||
					got.out_q !== e.out_q || got.packet_ok !== e.packet_ok ||
					got.sequence_ok !== e.sequence_ok || got.read_errors !== e.read_errors) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp kind %0d i %0d q %0d ok %0b seq %0b err %0d",
						e.result_kind, e.out_i, e.out_q, e.packet_ok, e.sequence_ok,
						e.read_errors);
					$display("          got kind %0d i %0d q %0d ok %0b seq %0b err %0d",
						got.result_kind, got.out_i, got.out_q,
						got.packet_ok, got.sequence_ok, got.read_errors);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	iqdfdc_in_if  in_ch();
	iqdfdc_out_if out_ch();

	iq_packet_deframer_dc_remove uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	deframer_board   board = new();
	deframe_result_t seen;
	int              src_idle_pct = 25;
	int              sink_idle_pct = 61;
	logic            hold_req = 1'b0;
	logic            hold_done = 1'b0;
	int              quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random back-pressure plus one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			seen.result_kind = kind_t'(out_ch.result_kind);
			seen.out_i       = out_ch.out_i;
			seen.out_q       = out_ch.out_q;
			seen.packet_ok   = out_ch.packet_ok;
			seen.sequence_ok = out_ch.sequence_ok;
			seen.read_errors = out_ch.read_errors;
			board.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send(deframe_req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.opcode         <= r.opcode;
		in_ch.payload_length <= r.payload_length;
		in_ch.sequence_req   <= r.sequence_req;
		in_ch.key_down       <= r.key_down;
		in_ch.sample_i       <= r.sample_i;
		in_ch.sample_q       <= r.sample_q;
		do @(posedge clk); while (!in_ch.ready);
		board.note_request(r);
		@(negedge clk);
	endtask

	task automatic send_header(logic [10:0] len, logic [15:0] seq, logic key);
		deframe_req_t r;
		r = '0;
		r.opcode = OP_HEADER;
		r.payload_length = len;
		r.sequence_req = seq;
		r.key_down = key;
		r.sample_i = 16'($urandom);
		r.sample_q = 16'($urandom);
		send(r);
	endtask

	task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq);
		deframe_req_t r;
		r = '0;
		r.opcode = OP_SAMPLE;
		r.payload_length = 11'($urandom);
		r.sequence_req = 16'($urandom);
		r.key_down = 1'($urandom);
		r.sample_i = si;
		r.sample_q = sq;
		send(r);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(19))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.due_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_traffic(int target);
		int goal;
		int pick;
		goal = board.predicted + target;
		while (board.predicted < goal) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				send_header(PACKET_BYTES,
					($urandom_range(99) < 85) ? board.next_seq : 16'($urandom),
					$urandom_range(99) < 12);
				repeat ($urandom_range(1, 24)) send_sample(rand_sample(), rand_sample());
			end else if (pick < 90) begin
				send_header(11'($urandom_range(2047)), 16'($urandom), 1'($urandom));
				repeat ($urandom_range(0, 3)) send_sample(rand_sample(), rand_sample());
			end else begin
				repeat ($urandom_range(1, 3)) send_sample(rand_sample(), rand_sample());
			end
		end
	endtask

	task automatic run_phase(logic [21:0] rate, logic rm, int mode, int target, logic hold);
		drain();
		write_reg(REG_SAMPLE_RATE, 32'(rate));
		write_reg(REG_REMOVE_DC, 32'(rm));
		src_idle_pct  = (mode == 0) ? 25 : (mode == 1) ? 61 : 0;
		sink_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 25 : 0;
		if (hold)
			hold_req = 1'b1;
		random_traffic(target);
	endtask

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		in_ch.valid          = 1'b0;
		in_ch.opcode         = OP_HEADER;
		in_ch.payload_length = '0;
		in_ch.sequence_req   = '0;
		in_ch.key_down       = 1'b0;
		in_ch.sample_i       = '0;
		in_ch.sample_q       = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero rate gives a fresh average on every sample of a good packet while the key is up
		write_reg(REG_SAMPLE_RATE, 32'd0);
		write_reg(REG_REMOVE_DC, 32'd1);
		send_sample(16'sh7fff, 16'sh8000);
		send_header(11'd0, 16'h0000, 1'b0);
		send_sample(16'sh1234, 16'sh4321);
		send_header(11'd2047, 16'hffff, 1'b1);
		send_header(PACKET_BYTES, 16'h0000, 1'b0);
		send_sample(16'sh8000, 16'sh7fff);
		send_sample(16'sh7fff, 16'sh8000);
		send_sample(16'sh0000, 16'shffff);
		send_header(PACKET_BYTES, 16'hffff, 1'b1);
		send_sample(16'shffff, 16'sh0001);
		send_sample(16'sh5555, 16'shaaaa);
		send_header(PACKET_BYTES, 16'h0000, 1'b0);
		send_sample(16'shaaaa, 16'sh5555);
		send_sample(16'sh0001, 16'shffff);
		send_header(11'd1027, 16'h0001, 1'b0);
		send_sample(16'sh0100, 16'sh0100);
		send_header(PACKET_BYTES, 16'h1234, 1'b0);
		repeat (5) send_sample(rand_sample(), rand_sample());

		run_phase(22'd1, 1'b1, 0, 200, 1'b0);
		run_phase(22'd3, 1'b0, 0, 150, 1'b0);
		run_phase(22'd5, 1'b1, 1, 200, 1'b0);
		run_phase(22'h3fffff, 1'b1, 1, 100, 1'b0);
		run_phase(22'd2, 1'b1, 2, 200, 1'b1);
		run_phase(SAMPLE_RATE_RESET, 1'b0, 2, 100, 1'b0);
		drain();

		if (board.mismatches == 0 && board.due_outputs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
